>>> src/ncs_pkg.sv
// shared types, codes and constant tables of the native contact similarity core
// no dependencies; used by the arithmetic units and the top level
`default_nettype none
package ncs_pkg;

  localparam int MAX_RESIDUES_DEF = 256;

  // word kinds
  localparam logic [1:0] KIND_LOAD = 2'd0;
  localparam logic [1:0] KIND_PAIR = 2'd1;
  localparam logic [1:0] KIND_END  = 2'd2;
  localparam logic [1:0] KIND_RSVD = 2'd3;

  // configuration register indexes
  localparam logic [1:0] REG_NUM_RES = 2'd0;
  localparam logic [1:0] REG_MIN_SEP = 2'd1;
  localparam logic [1:0] REG_SIG_EXP = 2'd2;

  localparam logic [8:0]  NUM_RES_RST = 9'd256;
  localparam logic [7:0]  MIN_SEP_RST = 8'd2;
  localparam logic [15:0] SIG_EXP_RST = 16'd2458;

  // log2(e) in q1.30
  localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;

  localparam int SUM_W  = 48;
  localparam int CNT_W  = 15;
  localparam int DVD_W  = SUM_W + 1;
  localparam int DVS_W  = 18;
  localparam int DCNT_W = 6;

  typedef enum logic [4:0] {
    S_IDLE,
    S_LOAD,
    S_SQ,
    S_SUM,
    S_SQRT,
    S_LOG_INIT,
    S_LOG,
    S_PMUL,
    S_POWP_GO,
    S_POW_P,
    S_UMUL,
    S_USH,
    S_W,
    S_Y,
    S_YCHK,
    S_POW_Y,
    S_ACC,
    S_END,
    S_DIV,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic        start;
    logic [15:0] frac;
  } pow_req_t;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  // 2^-(2^-k) in q.30 for k = 1..16
  typedef logic [29:0] pow_tab_t [16];

  function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] b;
    v   = v_in;
    res = '0;
    b   = 64'h4000_0000_0000_0000;
    for (int i = 0; i < 32; i++) begin
      if (v >= res + b) begin
        v   = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic pow_tab_t pow_tab();
    pow_tab_t    t;
    logic [63:0] c;
    c = 64'd1 << 29;
    for (int k = 0; k < 16; k++) begin
      c    = isqrt64(c << 30);
      t[k] = c[29:0];
    end
    return t;
  endfunction

endpackage
`default_nettype wire

>>> src/ncs_in_if.sv
// input channel of the native contact similarity core: valid, ready and one input word
// depends on nothing
`default_nettype none
interface ncs_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic [8:0]         res_i;
  logic [8:0]         res_j;
  logic signed [31:0] x_i;
  logic signed [31:0] y_i;
  logic signed [31:0] z_i;
  logic signed [31:0] x_j;
  logic signed [31:0] y_j;
  logic signed [31:0] z_j;
  logic [31:0]        native_value;
  logic               in_group_i;
  logic               in_group_j;

  modport source (
    output valid, kind, res_i, res_j, x_i, y_i, z_i, x_j, y_j, z_j,
    output native_value, in_group_i, in_group_j,
    input  ready
  );
  modport sink (
    input  valid, kind, res_i, res_j, x_i, y_i, z_i, x_j, y_j, z_j,
    input  native_value, in_group_i, in_group_j,
    output ready
  );
endinterface
`default_nettype wire

>>> src/ncs_out_if.sv
// result channel of the native contact similarity core: valid, ready and one result word
// depends on nothing
`default_nettype none
interface ncs_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] q_normalized;
  logic [14:0] pairs_counted;
  logic        norm_invalid;

  modport source (output valid, q_normalized, pairs_counted, norm_invalid, input ready);
  modport sink (input valid, q_normalized, pairs_counted, norm_invalid, output ready);
endinterface
`default_nettype wire

>>> src/ncs_pow2.sv
// iterative 2^-f unit, f a q.16 fraction, result in q.30, one fraction bit per cycle
// depends on ncs_pkg for the request type and the constant table
`default_nettype none
module ncs_pow2 (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire ncs_pkg::pow_req_t req,
  output logic                  done,
  output logic [30:0]           res
);

  localparam ncs_pkg::pow_tab_t CTAB = ncs_pkg::pow_tab();

  logic        busy_r;
  logic        done_r;
  logic [3:0]  k_r;
  logic [15:0] f_r;
  logic [30:0] r_r;
  logic [60:0] prod;

  assign prod = 61'(r_r) * 61'(CTAB[k_r]);
  assign done = done_r;
  assign res  = r_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      k_r    <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        k_r    <= '0;
      end else if (busy_r) begin
        k_r <= k_r + 4'd1;
        if (k_r == 4'd15) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      r_r <= 31'd1 << 30;
      f_r <= req.frac;
    end else if (busy_r) begin
      if (f_r[15]) begin
        r_r <= 31'(prod >> 30);
      end
      f_r <= {f_r[14:0], 1'b0};
    end
  end

endmodule
`default_nettype wire

>>> src/ncs_div.sv
// restoring divider for the frame normalisation, one quotient bit per cycle
// depends on ncs_pkg for the request type and widths
`default_nettype none
module ncs_div (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire ncs_pkg::div_req_t          req,
  output logic                            done,
  output logic [ncs_pkg::DVD_W-1:0]       quo
);

  logic                         busy_r;
  logic                         done_r;
  logic [ncs_pkg::DCNT_W-1:0]   cnt_r;
  logic [ncs_pkg::DVD_W-1:0]    q_r;
  logic [ncs_pkg::DVS_W-1:0]    dvs_r;
  logic [ncs_pkg::DVS_W-1:0]    rem_r;
  logic [ncs_pkg::DVS_W:0]      trial;
  logic                         fits;

  assign trial = {rem_r, q_r[ncs_pkg::DVD_W-1]};
  assign fits  = trial >= {1'b0, dvs_r};
  assign done  = done_r;
  assign quo   = q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == ncs_pkg::DCNT_W'(ncs_pkg::DVD_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      q_r   <= req.dividend;
      dvs_r <= req.divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      rem_r <= ncs_pkg::DVS_W'(fits ? trial - {1'b0, dvs_r} : trial);
      q_r   <= {q_r[ncs_pkg::DVD_W-2:0], fits};
    end
  end

endmodule
`default_nettype wire

>>> src/native_contact_similarity_core.sv
// top level of the native contact similarity core: native distance memory and pair sequencer
// depends on ncs_pkg, ncs_in_if, ncs_out_if, ncs_pow2 and ncs_div
//
// The block takes one word at a time. A load word writes the native distance of a residue
// pair into an on-chip memory of MAX_RESIDUES^2 words. A pair word that is filtered out leaves
// the block idle; a counted pair runs the bit-serial square root, the squaring log2 loop and
// up to two passes of the shared 2^-f unit. An end-of-frame word runs the 49-step divider when
// the normalisation is valid, then its result sits in an output register while the next words
// are accepted. The native memory is not cleared by reset: every entry must be loaded before a
// pair reads it.
`default_nettype none
module native_contact_similarity_core #(
  parameter int MAX_RESIDUES = ncs_pkg::MAX_RESIDUES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  ncs_in_if.sink           in_word,
  ncs_out_if.source        out_word,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  localparam int RW    = $clog2(MAX_RESIDUES);
  localparam int DEPTH = MAX_RESIDUES * MAX_RESIDUES;
  localparam int AW    = $clog2(DEPTH);

  function automatic logic [RW-1:0] fold(input logic [8:0] res);
    logic [8:0] v;
    v = res - 9'd1;
    for (int k = 8; k >= 0; k--) begin
      if (32'(v) >= (MAX_RESIDUES << k)) begin
        v = v - 9'(MAX_RESIDUES << k);
      end
    end
    return RW'(v);
  endfunction

  function automatic logic [29:0] absq14(input logic signed [31:0] a,
                                         input logic signed [31:0] b);
    logic signed [32:0] df;
    logic [32:0]        mag;
    df  = 33'(a) - 33'(b);
    mag = df[32] ? 33'(-df) : 33'(df);
    return mag[31:2];
  endfunction

  ncs_pkg::state_t state_r, state_nxt;

  logic [8:0]  num_res_r;
  logic [7:0]  min_sep_r;
  logic [15:0] sig_exp_r;

  logic [ncs_pkg::SUM_W-1:0] sum_r;
  logic [ncs_pkg::CNT_W-1:0] cnt_r;

  logic        out_valid_r;
  logic [31:0] q_r;
  logic        inv_r;
  logic [31:0] out_q_r;
  logic [14:0] out_cnt_r;
  logic        out_inv_r;
  logic        out_free;

  logic        in_acc;
  logic [8:0]  gap_in;
  logic        keep_in;

  logic [8:0]  res_i_r, res_j_r, gap_r;
  logic [31:0] native_r;
  logic [29:0] ax_r, ay_r, az_r;
  logic [59:0] sqx_r, sqy_r, sqz_r;
  logic [63:0] sq_v_r, sq_res_r, sq_bit_r, sq_try;

  logic [RW-1:0] row, col;
  logic [AW-1:0] addr;
  logic [31:0]   nat_mem [DEPTH];
  logic [31:0]   rd_r;
  logic          mem_we, rd_en;

  logic [32:0] dist_q16;
  logic [32:0] diff_r;
  logic [9:0]  m;
  logic [3:0]  ip;
  logic [3:0]  ip_r;
  logic [30:0] lx_r;
  logic [15:0] frac_r;
  logic [3:0]  lcnt_r;
  logic [61:0] lsq;
  logic [31:0] lt;

  logic [21:0] p_r;
  logic [33:0] um_r;
  logic [33:0] u_sh;
  logic        u_big;
  logic [18:0] u_r;
  logic [21:0] w_r, y_r;
  logic        y_big;
  logic [30:0] term_r;
  logic [ncs_pkg::SUM_W:0] sum_add;

  logic signed [10:0] a_s, b_s;
  logic               norm_ok;

  ncs_pkg::pow_req_t pow_req;
  logic              pow_done;
  logic [30:0]       pow_res;
  ncs_pkg::div_req_t div_req;
  logic              div_done;
  logic [ncs_pkg::DVD_W-1:0] div_quo;

  ncs_pow2 u_pow2 (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (pow_req),
    .done  (pow_done),
    .res   (pow_res)
  );

  ncs_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .done  (div_done),
    .quo   (div_quo)
  );

  // input side
  assign in_acc  = in_word.valid && in_word.ready;
  assign gap_in  = (in_word.res_i > in_word.res_j) ? in_word.res_i - in_word.res_j
                                                   : in_word.res_j - in_word.res_i;
  assign keep_in = in_word.in_group_i && in_word.in_group_j && (gap_in > {1'b0, min_sep_r});

  // native memory address
  assign row  = fold(res_i_r);
  assign col  = fold(res_j_r);
  assign addr = AW'(row) * AW'(MAX_RESIDUES) + AW'(col);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      nat_mem[addr] <= native_r;
    end
    if (rd_en) begin
      rd_r <= nat_mem[addr];
    end
  end

  // datapath helpers
  assign sq_try   = sq_res_r + sq_bit_r;
  assign dist_q16 = {sq_res_r[30:0], 2'b00};
  assign m        = {1'b0, gap_r} + 10'd1;
  assign lsq      = 62'(lx_r) * 62'(lx_r);
  assign lt       = 32'(lsq >> 30);
  assign u_sh     = um_r >> p_r[21:16];
  assign u_big    = |u_sh[33:19];
  assign y_big    = y_r[21:16] > 6'd30;
  assign sum_add  = {1'b0, sum_r} + (ncs_pkg::SUM_W + 1)'(term_r);
  assign a_s      = $signed({2'b00, num_res_r}) - $signed({3'b000, min_sep_r});
  assign b_s      = a_s - 11'sd1;
  assign norm_ok  = b_s > 11'sd0;
  assign out_free = !out_valid_r || out_word.ready;

  always_comb begin
    ip = '0;
    for (int i = 0; i < 10; i++) begin
      if (m[i]) begin
        ip = 4'(i);
      end
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ncs_pkg::S_IDLE: begin
        if (in_acc) begin
          unique case (in_word.kind)
            ncs_pkg::KIND_LOAD: state_nxt = ncs_pkg::S_LOAD;
            ncs_pkg::KIND_PAIR: state_nxt = keep_in ? ncs_pkg::S_SQ : ncs_pkg::S_IDLE;
            ncs_pkg::KIND_END:  state_nxt = ncs_pkg::S_END;
            default:            state_nxt = ncs_pkg::S_IDLE;
          endcase
        end
      end
      ncs_pkg::S_LOAD:     state_nxt = ncs_pkg::S_IDLE;
      ncs_pkg::S_SQ:       state_nxt = ncs_pkg::S_SUM;
      ncs_pkg::S_SUM:      state_nxt = ncs_pkg::S_SQRT;
      ncs_pkg::S_SQRT:     if (sq_bit_r[0]) state_nxt = ncs_pkg::S_LOG_INIT;
      ncs_pkg::S_LOG_INIT: state_nxt = ncs_pkg::S_LOG;
      ncs_pkg::S_LOG:      if (lcnt_r == 4'd15) state_nxt = ncs_pkg::S_PMUL;
      ncs_pkg::S_PMUL:     state_nxt = ncs_pkg::S_POWP_GO;
      ncs_pkg::S_POWP_GO:  state_nxt = ncs_pkg::S_POW_P;
      ncs_pkg::S_POW_P:    if (pow_done) state_nxt = ncs_pkg::S_UMUL;
      ncs_pkg::S_UMUL:     state_nxt = ncs_pkg::S_USH;
      ncs_pkg::S_USH:      state_nxt = u_big ? ncs_pkg::S_ACC : ncs_pkg::S_W;
      ncs_pkg::S_W:        state_nxt = ncs_pkg::S_Y;
      ncs_pkg::S_Y:        state_nxt = ncs_pkg::S_YCHK;
      ncs_pkg::S_YCHK:     state_nxt = y_big ? ncs_pkg::S_ACC : ncs_pkg::S_POW_Y;
      ncs_pkg::S_POW_Y:    if (pow_done) state_nxt = ncs_pkg::S_ACC;
      ncs_pkg::S_ACC:      state_nxt = ncs_pkg::S_IDLE;
      ncs_pkg::S_END:      state_nxt = norm_ok ? ncs_pkg::S_DIV : ncs_pkg::S_EMIT;
      ncs_pkg::S_DIV:      if (div_done) state_nxt = ncs_pkg::S_EMIT;
      ncs_pkg::S_EMIT:     if (out_free) state_nxt = ncs_pkg::S_IDLE;
      default:             state_nxt = ncs_pkg::S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_word.ready    = (state_r == ncs_pkg::S_IDLE);
    mem_we           = (state_r == ncs_pkg::S_LOAD);
    rd_en            = (state_r == ncs_pkg::S_SQ);
    pow_req.start    = 1'b0;
    pow_req.frac     = p_r[15:0];
    div_req.start    = 1'b0;
    div_req.dividend = {sum_r, 1'b0};
    div_req.divisor  = 18'(a_s[8:0]) * 18'(b_s[8:0]);
    unique case (state_r)
      ncs_pkg::S_POWP_GO: pow_req.start = 1'b1;
      ncs_pkg::S_YCHK: begin
        pow_req.start = !y_big;
        pow_req.frac  = y_r[15:0];
      end
      ncs_pkg::S_END:     div_req.start = norm_ok;
      default: ;
    endcase
  end

  assign out_word.valid         = out_valid_r;
  assign out_word.q_normalized  = out_q_r;
  assign out_word.pairs_counted = out_cnt_r;
  assign out_word.norm_invalid  = out_inv_r;

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ncs_pkg::S_IDLE;
      num_res_r   <= ncs_pkg::NUM_RES_RST;
      min_sep_r   <= ncs_pkg::MIN_SEP_RST;
      sig_exp_r   <= ncs_pkg::SIG_EXP_RST;
      sum_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          ncs_pkg::REG_NUM_RES: num_res_r <= cfg_data[8:0];
          ncs_pkg::REG_MIN_SEP: min_sep_r <= cfg_data[7:0];
          ncs_pkg::REG_SIG_EXP: sig_exp_r <= cfg_data;
          default: ;
        endcase
      end
      if (state_r == ncs_pkg::S_ACC) begin
        sum_r <= sum_add[ncs_pkg::SUM_W] ? '1 : sum_add[ncs_pkg::SUM_W-1:0];
        if (cnt_r != '1) begin
          cnt_r <= cnt_r + 1'b1;
        end
      end
      if (state_r == ncs_pkg::S_EMIT && out_free) begin
        out_valid_r <= 1'b1;
        sum_r       <= '0;
        cnt_r       <= '0;
      end else if (out_word.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      ncs_pkg::S_IDLE: begin
        if (in_acc) begin
          res_i_r  <= in_word.res_i;
          res_j_r  <= in_word.res_j;
          gap_r    <= gap_in;
          native_r <= in_word.native_value;
          ax_r     <= absq14(in_word.x_i, in_word.x_j);
          ay_r     <= absq14(in_word.y_i, in_word.y_j);
          az_r     <= absq14(in_word.z_i, in_word.z_j);
        end
      end
      ncs_pkg::S_SQ: begin
        sqx_r <= 60'(ax_r) * 60'(ax_r);
        sqy_r <= 60'(ay_r) * 60'(ay_r);
        sqz_r <= 60'(az_r) * 60'(az_r);
      end
      ncs_pkg::S_SUM: begin
        sq_v_r   <= 64'(sqx_r) + 64'(sqy_r) + 64'(sqz_r);
        sq_res_r <= '0;
        sq_bit_r <= 64'h4000_0000_0000_0000;
      end
      ncs_pkg::S_SQRT: begin
        if (sq_v_r >= sq_try) begin
          sq_v_r   <= sq_v_r - sq_try;
          sq_res_r <= (sq_res_r >> 1) + sq_bit_r;
        end else begin
          sq_res_r <= sq_res_r >> 1;
        end
        sq_bit_r <= sq_bit_r >> 2;
      end
      ncs_pkg::S_LOG_INIT: begin
        diff_r <= (dist_q16 > {1'b0, rd_r}) ? dist_q16 - {1'b0, rd_r}
                                            : {1'b0, rd_r} - dist_q16;
        lx_r   <= 31'(m) << (5'd30 - 5'(ip));
        ip_r   <= ip;
        frac_r <= '0;
        lcnt_r <= '0;
      end
      ncs_pkg::S_LOG: begin
        lcnt_r <= lcnt_r + 4'd1;
        frac_r <= {frac_r[14:0], lt[31]};
        lx_r   <= lt[31] ? lt[31:1] : lt[30:0];
      end
      ncs_pkg::S_PMUL: begin
        p_r <= 22'((36'(sig_exp_r) * 36'({ip_r, frac_r})) >> 14);
      end
      ncs_pkg::S_UMUL: begin
        um_r <= 34'((62'(diff_r) * 62'(pow_res[30:2])) >> 28);
      end
      ncs_pkg::S_USH: begin
        u_r <= u_sh[18:0];
        if (u_big) begin
          term_r <= '0;
        end
      end
      ncs_pkg::S_W: begin
        w_r <= 22'((38'(u_r) * 38'(u_r)) >> 16);
      end
      ncs_pkg::S_Y: begin
        y_r <= 22'((53'(w_r) * 53'(ncs_pkg::LOG2E_Q30)) >> 31);
      end
      ncs_pkg::S_YCHK: begin
        if (y_big) begin
          term_r <= '0;
        end
      end
      ncs_pkg::S_POW_Y: begin
        if (pow_done) begin
          term_r <= pow_res >> y_r[21:16];
        end
      end
      ncs_pkg::S_END: begin
        inv_r <= !norm_ok;
        q_r   <= '0;
      end
      ncs_pkg::S_DIV: begin
        if (div_done) begin
          q_r <= (|div_quo[ncs_pkg::DVD_W-1:32]) ? '1 : div_quo[31:0];
        end
      end
      ncs_pkg::S_EMIT: begin
        if (out_free) begin
          out_q_r   <= q_r;
          out_cnt_r <= cnt_r;
          out_inv_r <= inv_r;
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire
